// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while not in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked while not in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/xed_pkg.sv =====
// Shared types, constants and helper functions for the entity decoder.
package xed_pkg;

  localparam int MAX_REF_LEN_DEF = 32;
  localparam int NUM_NAMES       = 5;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_XL   = 8'h78;
  localparam logic [7:0] CH_XU   = 8'h58;

  localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;

  typedef logic [7:0] byte_t;

  // stack chain control: push shifts towards the tail, pop towards the head
  typedef struct packed {
    logic  push;
    logic  pop;
    byte_t din;
  } chain_ctl_t;

  typedef struct packed {
    logic  clear;
    logic  add;
    byte_t ch;
  } parse_ctl_t;

  typedef struct packed {
    logic        num_ok;
    logic        name_ok;
    logic [20:0] value;
    byte_t       name_char;
  } parse_res_t;

  typedef struct packed {
    logic [2:0]       count;
    logic [3:0][7:0]  bytes;
  } utf8_t;

  function automatic byte_t fold_case(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [2:0] name_len(input int k);
    logic [2:0] r;
    case (k)
      0: r = 3'd3;
      1: r = 3'd4;
      2: r = 3'd2;
      3: r = 3'd2;
      4: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // lower-case spelling of each name: amp, apos, gt, lt, quot
  function automatic byte_t name_char_at(input int k, input logic [1:0] i);
    byte_t r;
    r = 8'h00;
    case (k)
      0: begin
        case (i)
          2'd0: r = 8'h61;
          2'd1: r = 8'h6D;
          2'd2: r = 8'h70;
          default: r = 8'h00;
        endcase
      end
      1: begin
        case (i)
          2'd0: r = 8'h61;
          2'd1: r = 8'h70;
          2'd2: r = 8'h6F;
          default: r = 8'h73;
        endcase
      end
      2: begin
        case (i)
          2'd0: r = 8'h67;
          2'd1: r = 8'h74;
          default: r = 8'h00;
        endcase
      end
      3: begin
        case (i)
          2'd0: r = 8'h6C;
          2'd1: r = 8'h74;
          default: r = 8'h00;
        endcase
      end
      4: begin
        case (i)
          2'd0: r = 8'h71;
          2'd1: r = 8'h75;
          2'd2: r = 8'h6F;
          default: r = 8'h74;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t name_result(input int k);
    byte_t r;
    case (k)
      0: r = 8'h26;
      1: r = 8'h27;
      2: r = 8'h3E;
      3: r = 8'h3C;
      4: r = 8'h22;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] digit_of(input byte_t c, input logic hex);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (hex && c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (hex && c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] v);
    utf8_t r;
    r.bytes = '0;
    if (v <= 21'h7F) begin
      r.count    = 3'd1;
      r.bytes[0] = v[7:0];
    end else if (v <= 21'h7FF) begin
      r.count    = 3'd2;
      r.bytes[0] = {3'b110, v[10:6]};
      r.bytes[1] = {2'b10, v[5:0]};
    end else if (v <= 21'hFFFF) begin
      r.count    = 3'd3;
      r.bytes[0] = {4'b1110, v[15:12]};
      r.bytes[1] = {2'b10, v[11:6]};
      r.bytes[2] = {2'b10, v[5:0]};
    end else begin
      r.count    = 3'd4;
      r.bytes[0] = {5'b11110, v[20:18]};
      r.bytes[1] = {2'b10, v[17:12]};
      r.bytes[2] = {2'b10, v[11:6]};
      r.bytes[3] = {2'b10, v[5:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/xed_cell.sv =====
// One byte cell of a push/pop stack chain.
module xed_cell (
  input  logic               clk,
  input  xed_pkg::chain_ctl_t ctl,
  input  xed_pkg::byte_t     prev_byte,
  input  xed_pkg::byte_t     next_byte,
  output xed_pkg::byte_t     q
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q <= prev_byte;
    end else if (ctl.pop) begin
      q <= next_byte;
    end
  end

endmodule

// ===== rtl/core/xed_parse.sv =====
// Incremental parser for the bytes of an open reference.
module xed_parse #(
  parameter int MAX_REF_LEN = xed_pkg::MAX_REF_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  xed_pkg::parse_ctl_t              ctl,
  input  logic [$clog2(MAX_REF_LEN+1)-1:0] h,
  output xed_pkg::parse_res_t              res
);

  localparam int HW = $clog2(MAX_REF_LEN + 1);

  logic        is_num;
  logic        hex;
  logic        ndig;
  logic        over;
  logic        bad;
  logic [20:0] value;
  logic [xed_pkg::NUM_NAMES-1:0] mask;
  logic [xed_pkg::NUM_NAMES-1:0] mask_next;

  logic        first;
  logic [4:0]  dig;
  logic [24:0] prod;

  assign first = (h == '0);
  assign dig   = xed_pkg::digit_of(ctl.ch, hex);

  always_comb begin
    if (hex) begin
      prod = {value, 4'b0000} + 25'(dig[3:0]);
    end else begin
      prod = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + 25'(dig[3:0]);
    end
  end

  always_comb begin
    for (int k = 0; k < xed_pkg::NUM_NAMES; k++) begin
      mask_next[k] = (first || mask[k])
                  && (h < HW'(xed_pkg::name_len(k)))
                  && (xed_pkg::fold_case(ctl.ch) == xed_pkg::name_char_at(k, h[1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      is_num <= 1'b0;
      hex    <= 1'b0;
      ndig   <= 1'b0;
      over   <= 1'b0;
      bad    <= 1'b0;
      value  <= '0;
      mask   <= '0;
    end else if (ctl.add) begin
      mask <= mask_next;
      if (first) begin
        is_num <= (ctl.ch == xed_pkg::CH_HASH);
      end else if (is_num) begin
        if (h == HW'(1) && (ctl.ch == xed_pkg::CH_XL || ctl.ch == xed_pkg::CH_XU)) begin
          hex <= 1'b1;
        end else if (!dig[4]) begin
          bad <= 1'b1;
        end else begin
          ndig <= 1'b1;
          if (!over) begin
            if (prod > 25'(xed_pkg::MAX_SCALAR)) begin
              over <= 1'b1;
            end else begin
              value <= prod[20:0];
            end
          end
        end
      end
    end
  end

  always_comb begin
    res.num_ok = is_num && !bad && ndig && !over
              && !(value >= xed_pkg::SURR_LO && value <= xed_pkg::SURR_HI);
    res.value     = value;
    res.name_ok   = 1'b0;
    res.name_char = 8'h00;
    for (int k = 0; k < xed_pkg::NUM_NAMES; k++) begin
      if (mask[k] && h == HW'(xed_pkg::name_len(k))) begin
        res.name_ok   = 1'b1;
        res.name_char = xed_pkg::name_result(k);
      end
    end
  end

endmodule

// ===== rtl/core/xml_entity_decoder_utf8.sv =====
// XML character reference decoder: text bytes in, literal or UTF-8 bytes out.
// Each result waits in a pending register before the output register; the last of a request leaves on the flush.
// A plain byte goes through accept, decode, end check and flush; each further queued or UTF-8
//   byte adds a decode step, a failed reference adds the '&' out, a move per held byte and a return.
// The single decode step on the queue head sets the pace and output stalls hold it; input is taken only in idle.
// Reset (rst, synchronous, active high) empties both chains and the output.
module xml_entity_decoder_utf8 #(
  parameter int MAX_REF_LEN = xed_pkg::MAX_REF_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // [0] text_done
);

  // Two stacks of identical cells hold the work:
  //   queue chain - bytes still to decode, head in cell 0;
  //   held chain  - bytes of the open reference, newest in cell 0.
  // On failure the held bytes are popped newest first and pushed onto the
  // queue head, so the queue replays them oldest first before the byte
  // that ended the attempt. The '&' itself is never stored.
  localparam int DEPTH = MAX_REF_LEN + 1;
  localparam int QW    = $clog2(DEPTH + 1);
  localparam int HW    = $clog2(MAX_REF_LEN + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_MOVE = 3'd2;
  localparam logic [2:0] S_UTF  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic          open;
  logic          open_next;
  logic          endf;
  logic [QW-1:0] qcnt;
  logic [QW-1:0] qcnt_next;
  logic [HW-1:0] hcnt;
  logic [HW-1:0] hcnt_next;

  // one result is kept back so the last of a request can be flagged
  logic           pend_v;
  xed_pkg::byte_t pend_b;

  xed_pkg::utf8_t utf;
  xed_pkg::utf8_t enc;
  logic [1:0]     utf_idx;

  xed_pkg::chain_ctl_t qctl;
  xed_pkg::chain_ctl_t hctl;
  xed_pkg::parse_ctl_t pctl;
  xed_pkg::parse_res_t pres;

  xed_pkg::byte_t qc [DEPTH];
  xed_pkg::byte_t hc [DEPTH];
  xed_pkg::byte_t front;

  logic           emit;
  xed_pkg::byte_t ebyte;
  logic           ofree;
  logic           emit_ok;
  logic           load_utf;
  logic           flush;

  // ---- cell chains ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_chain
    xed_cell u_qcell (
      .clk       (clk),
      .ctl       (qctl),
      .prev_byte ((i == 0) ? qctl.din : qc[(i == 0) ? 0 : i - 1]),
      .next_byte ((i == DEPTH - 1) ? 8'h00 : qc[(i == DEPTH - 1) ? i : i + 1]),
      .q         (qc[i])
    );
    xed_cell u_hcell (
      .clk       (clk),
      .ctl       (hctl),
      .prev_byte ((i == 0) ? hctl.din : hc[(i == 0) ? 0 : i - 1]),
      .next_byte ((i == DEPTH - 1) ? 8'h00 : hc[(i == DEPTH - 1) ? i : i + 1]),
      .q         (hc[i])
    );
  end

  xed_parse #(
    .MAX_REF_LEN (MAX_REF_LEN)
  ) u_parse (
    .clk (clk),
    .rst (rst),
    .ctl (pctl),
    .h   (hcnt),
    .res (pres)
  );

  assign front    = qc[0];
  assign enc      = xed_pkg::utf8_encode(pres.value);
  assign s_tready = (state == S_IDLE);
  assign ofree    = !m_tvalid || m_tready;
  assign emit_ok  = !pend_v || ofree;

  // ---- decode step ----
  always_comb begin
    state_next = state;
    open_next  = open;
    qcnt_next  = qcnt;
    hcnt_next  = hcnt;
    qctl       = '{push: 1'b0, pop: 1'b0, din: front};
    hctl       = '{push: 1'b0, pop: 1'b0, din: front};
    pctl       = '{clear: 1'b0, add: 1'b0, ch: front};
    emit       = 1'b0;
    ebyte      = front;
    load_utf   = 1'b0;
    flush      = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          qctl.push  = 1'b1;
          qctl.din   = s_tdata;
          qcnt_next  = QW'(1);
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (qcnt == '0) begin
          if (open && endf) begin
            // end of text with a reference still open: fail it
            if (emit_ok) begin
              emit       = 1'b1;
              ebyte      = xed_pkg::CH_AMP;
              open_next  = 1'b0;
              state_next = S_MOVE;
            end
          end else begin
            state_next = S_FIN;
          end
        end else if (!open) begin
          if (front == xed_pkg::CH_AMP) begin
            qctl.pop   = 1'b1;
            qcnt_next  = qcnt - QW'(1);
            open_next  = 1'b1;
            pctl.clear = 1'b1;
          end else if (emit_ok) begin
            emit      = 1'b1;
            qctl.pop  = 1'b1;
            qcnt_next = qcnt - QW'(1);
          end
        end else if (front == xed_pkg::CH_SEMI && (pres.num_ok || pres.name_ok)) begin
          if (emit_ok) begin
            emit      = 1'b1;
            qctl.pop  = 1'b1;
            qcnt_next = qcnt - QW'(1);
            open_next = 1'b0;
            // held bytes of a decoded reference are simply dropped
            hcnt_next = '0;
            if (pres.num_ok) begin
              ebyte = enc.bytes[0];
              if (enc.count != 3'd1) begin
                load_utf   = 1'b1;
                state_next = S_UTF;
              end
            end else begin
              ebyte = pres.name_char;
            end
          end
        end else if (front != xed_pkg::CH_SEMI && hcnt < HW'(MAX_REF_LEN)) begin
          hctl.push = 1'b1;
          qctl.pop  = 1'b1;
          pctl.add  = 1'b1;
          qcnt_next = qcnt - QW'(1);
          hcnt_next = hcnt + HW'(1);
        end else if (emit_ok) begin
          // bad reference or window full: '&' out, replay held bytes
          emit       = 1'b1;
          ebyte      = xed_pkg::CH_AMP;
          open_next  = 1'b0;
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        if (hcnt == '0) begin
          state_next = S_RUN;
        end else begin
          hctl.pop  = 1'b1;
          qctl.push = 1'b1;
          qctl.din  = hc[0];
          hcnt_next = hcnt - HW'(1);
          qcnt_next = qcnt + QW'(1);
        end
      end
      S_UTF: begin
        if (emit_ok) begin
          emit  = 1'b1;
          ebyte = utf.bytes[utf_idx];
          if ({1'b0, utf_idx} == utf.count - 3'd1) begin
            state_next = S_RUN;
          end
        end
      end
      S_FIN: begin
        if (!pend_v) begin
          state_next = S_IDLE;
        end else if (ofree) begin
          flush      = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      open    <= 1'b0;
      endf    <= 1'b0;
      qcnt    <= '0;
      hcnt    <= '0;
      pend_v  <= 1'b0;
      utf_idx <= '0;
    end else begin
      state <= state_next;
      open  <= open_next;
      qcnt  <= qcnt_next;
      hcnt  <= hcnt_next;
      if (state == S_IDLE && s_tvalid) begin
        endf <= s_tlast;
      end
      if (emit) begin
        pend_v <= 1'b1;
      end else if (flush) begin
        pend_v <= 1'b0;
      end
      if (load_utf) begin
        utf_idx <= 2'd1;
      end else if (state == S_UTF && emit) begin
        utf_idx <= utf_idx + 2'd1;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (emit) begin
      pend_b <= ebyte;
    end
    if (load_utf) begin
      utf <= enc;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((emit && pend_v) || flush) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((emit && pend_v) || flush) begin
      m_tdata <= pend_b;
      m_tlast <= flush;
      m_tuser <= flush && endf;
    end
  end

endmodule

// ===== rtl/core/xed_checker.sv =====
// Port-level checker for the entity decoder, bound to the top level.
`include "assert_macros.svh"

module xed_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // the end of the text is always the end of a request's results
  `ASSERT_IMPLIES(a_done_last, clk, rst, m_tvalid && m_tuser, m_tlast)
  // one request at a time: no new input right after one is taken
  `ASSERT_NEXT(a_one_req, clk, rst, s_tvalid && s_tready, !s_tready)
  // output is empty straight after reset
  `ASSERT_IMPLIES(a_rst_empty, clk, 1'b0, $past(rst), !m_tvalid)

endmodule

bind xml_entity_decoder_utf8 xed_checker u_xed_checker (.*);
